[design/dwpi_pkg.sv]
// Package for the dual-wheel PI speed controller.
// Holds register indexes, reset values and field widths shared by the design.
// No dependencies.
package dwpi_pkg;

  localparam int COUNT_BITS_DEF    = 16;
  localparam int INTEGRAL_BITS_DEF = 32;

  localparam int ENC_W    = 16;
  localparam int TGT_W    = 16;
  localparam int GAIN_W   = 16;
  localparam int LIM_W    = 10;
  localparam int SPEED_W  = 16;
  localparam int ERR_W    = 17;
  localparam int EFFORT_W = 11;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 2 * ENC_W;
  localparam int OUT_DATA_W = 2 * EFFORT_W + 2 * SPEED_W + 2 * ERR_W;

  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_LEFT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_RIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED_SCALE  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PROP_GAIN    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_INTEG_GAIN   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_EFFORT_LIMIT = 3'd5;

  localparam logic [TGT_W-1:0]  TARGET_RESET = 16'd0;
  localparam logic [GAIN_W-1:0] SCALE_RESET  = 16'd256;
  localparam logic [GAIN_W-1:0] KP_RESET     = 16'd256;
  localparam logic [GAIN_W-1:0] KI_RESET     = 16'd0;
  localparam logic [LIM_W-1:0]  LIMIT_RESET  = 10'd300;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // Rounding offset for a Q8.8 product before the floor shift.
  localparam int FRAC_BITS = 8;
  localparam int ROUND_HALF = 128;

endpackage

[design/dual_wheel_pi_speed_control.sv]
// Top level of the dual-wheel PI speed controller.
// Depends on dwpi_pkg for register indexes, reset values and widths.
//
// Usage: configuration registers are written through cfg_we, cfg_addr and
// cfg_wdata while the block is idle. Input items arrive on the s_ stream:
// s_tuser selects a control tick or a start, and s_tdata carries both encoder
// counts. A start transfer clears both integrators and gives no result. A
// tick transfer runs both wheels in turn through one shared multiplier
// under a small sequencer, with these steps per wheel: speed product,
// rounding, error and integrator, two gain products, accumulate and clamp.
// After the second wheel the result is registered onto m_ in the output
// step, once the output register is free. No new item is taken until the
// tick is through, since s_tready is high only while the
// sequencer is idle. The result waits in an output register: a new item can
// be taken while it is pending, but a finished result waits in the last step
// until the receiver has taken the previous one. Reset clears the sequencer,
// the output valid, the encoder history and the integrators, and loads the
// register defaults.
module dual_wheel_pi_speed_control #(
  parameter int COUNT_BITS    = dwpi_pkg::COUNT_BITS_DEF,
  parameter int INTEGRAL_BITS = dwpi_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [dwpi_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dwpi_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // Fields from bit 0: enc_left[15:0], enc_right[31:16].
  input  logic [dwpi_pkg::IN_DATA_W-1:0]    s_tdata,
  // Fields from bit 0: op[0].
  input  logic [0:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // Fields from bit 0: effort_left[10:0], effort_right[21:11], speed_left[37:22],
  // speed_right[53:38], speed_err_left[70:54], speed_err_right[87:71].
  output logic [dwpi_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int CB  = COUNT_BITS;
  localparam int IB  = INTEGRAL_BITS;
  localparam int A0  = (CB > IB) ? CB : IB;
  localparam int A_W = (A0 > dwpi_pkg::ERR_W) ? A0 : dwpi_pkg::ERR_W;
  localparam int B_W = dwpi_pkg::GAIN_W + 1;
  localparam int P_W = A_W + B_W;
  localparam int ACC_W = P_W + 1;
  localparam int SW = dwpi_pkg::SPEED_W;
  localparam int EW = dwpi_pkg::ERR_W;
  localparam int FW = dwpi_pkg::EFFORT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MSPD = 4'd1;
  localparam logic [3:0] S_SPD  = 4'd2;
  localparam logic [3:0] S_ERR  = 4'd3;
  localparam logic [3:0] S_MP   = 4'd4;
  localparam logic [3:0] S_MI   = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_EFF  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic signed [IB-1:0] INT_MAX = {1'b0, {(IB-1){1'b1}}};
  localparam logic signed [IB-1:0] INT_MIN = {1'b1, {(IB-1){1'b0}}};

  logic [3:0] state;
  logic       wheel;

  logic signed [dwpi_pkg::TGT_W-1:0] tgt_l;
  logic signed [dwpi_pkg::TGT_W-1:0] tgt_r;
  logic [dwpi_pkg::GAIN_W-1:0]       scale;
  logic [dwpi_pkg::GAIN_W-1:0]       kp;
  logic [dwpi_pkg::GAIN_W-1:0]       ki;
  logic [dwpi_pkg::LIM_W-1:0]        limit;

  logic signed [dwpi_pkg::ENC_W-1:0] enc_l;
  logic signed [dwpi_pkg::ENC_W-1:0] enc_r;
  logic [CB-1:0]                     last_cnt [2];
  logic signed [IB-1:0]              integ [2];
  logic signed [SW-1:0]              spd_q [2];
  logic signed [EW-1:0]              err_q [2];
  logic signed [FW-1:0]              eff_q [2];

  logic signed [P_W-1:0]   mul_q;
  logic signed [ACC_W-1:0] acc;

  logic                              in_xfer;
  logic signed [dwpi_pkg::ENC_W-1:0] enc_sel;
  logic [CB-1:0]                     cur_cnt;
  logic [CB-1:0]                     delta;
  logic signed [dwpi_pkg::TGT_W-1:0] tgt_sel;
  logic signed [A_W-1:0]             mul_a;
  logic signed [B_W-1:0]             mul_b;
  logic signed [P_W-1:0]             mul_p;
  logic signed [P_W:0]               spd_rnd;
  logic signed [SW-1:0]              spd_sat;
  logic signed [EW-1:0]              err_next;
  logic signed [IB:0]                int_sum;
  logic signed [IB-1:0]              integ_next;
  logic signed [ACC_W:0]             eff_rnd;
  logic signed [ACC_W:0]             lim_x;
  logic signed [FW-1:0]              eff_clamp;

  assign in_xfer  = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE);

  assign enc_sel = wheel ? enc_r : enc_l;
  assign cur_cnt = CB'(enc_sel);
  assign delta   = cur_cnt - last_cnt[wheel];
  assign tgt_sel = wheel ? tgt_r : tgt_l;

  always_comb begin
    case (state)
      S_MSPD: begin
        mul_a = A_W'(signed'(delta));
        mul_b = signed'({1'b0, scale});
      end
      S_MP: begin
        mul_a = A_W'(err_q[wheel]);
        mul_b = signed'({1'b0, kp});
      end
      default: begin
        mul_a = A_W'(integ[wheel]);
        mul_b = signed'({1'b0, ki});
      end
    endcase
  end

  assign mul_p = P_W'(mul_a) * P_W'(mul_b);

  assign spd_rnd = ((P_W+1)'(mul_q) + (P_W+1)'(dwpi_pkg::ROUND_HALF)) >>> dwpi_pkg::FRAC_BITS;

  always_comb begin
    if (spd_rnd > (P_W+1)'(32767)) begin
      spd_sat = {1'b0, {(SW-1){1'b1}}};
    end else if (spd_rnd < -(P_W+1)'(32768)) begin
      spd_sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      spd_sat = SW'(spd_rnd);
    end
  end

  assign err_next = EW'(tgt_sel) - EW'(spd_q[wheel]);
  assign int_sum  = (IB+1)'(integ[wheel]) + (IB+1)'(err_next);

  always_comb begin
    if (int_sum[IB] != int_sum[IB-1]) begin
      integ_next = int_sum[IB] ? INT_MIN : INT_MAX;
    end else begin
      integ_next = int_sum[IB-1:0];
    end
  end

  assign eff_rnd = ((ACC_W+1)'(acc) + (ACC_W+1)'(dwpi_pkg::ROUND_HALF)) >>> dwpi_pkg::FRAC_BITS;
  assign lim_x   = signed'((ACC_W+1)'(limit));

  always_comb begin
    if (eff_rnd > lim_x) begin
      eff_clamp = FW'(lim_x);
    end else if (eff_rnd < -lim_x) begin
      eff_clamp = FW'(-lim_x);
    end else begin
      eff_clamp = FW'(eff_rnd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_l <= dwpi_pkg::TARGET_RESET;
      tgt_r <= dwpi_pkg::TARGET_RESET;
      scale <= dwpi_pkg::SCALE_RESET;
      kp    <= dwpi_pkg::KP_RESET;
      ki    <= dwpi_pkg::KI_RESET;
      limit <= dwpi_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        dwpi_pkg::REG_TARGET_LEFT:  tgt_l <= cfg_wdata;
        dwpi_pkg::REG_TARGET_RIGHT: tgt_r <= cfg_wdata;
        dwpi_pkg::REG_SPEED_SCALE:  scale <= cfg_wdata;
        dwpi_pkg::REG_PROP_GAIN:    kp    <= cfg_wdata;
        dwpi_pkg::REG_INTEG_GAIN:   ki    <= cfg_wdata;
        dwpi_pkg::REG_EFFORT_LIMIT: limit <= cfg_wdata[dwpi_pkg::LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wheel    <= 1'b0;
      m_tvalid <= 1'b0;
      last_cnt[0] <= '0;
      last_cnt[1] <= '0;
      integ[0]    <= '0;
      integ[1]    <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (s_tuser[0] == dwpi_pkg::OP_START) begin
              integ[0] <= '0;
              integ[1] <= '0;
            end else begin
              enc_l <= s_tdata[dwpi_pkg::ENC_W-1:0];
              enc_r <= s_tdata[dwpi_pkg::IN_DATA_W-1:dwpi_pkg::ENC_W];
              wheel <= 1'b0;
              state <= S_MSPD;
            end
          end
        end
        S_MSPD: begin
          mul_q           <= mul_p;
          last_cnt[wheel] <= cur_cnt;
          state           <= S_SPD;
        end
        S_SPD: begin
          spd_q[wheel] <= spd_sat;
          state        <= S_ERR;
        end
        S_ERR: begin
          err_q[wheel] <= err_next;
          integ[wheel] <= integ_next;
          state        <= S_MP;
        end
        S_MP: begin
          mul_q <= mul_p;
          state <= S_MI;
        end
        S_MI: begin
          acc   <= ACC_W'(mul_q);
          mul_q <= mul_p;
          state <= S_ACC;
        end
        S_ACC: begin
          acc   <= acc + ACC_W'(mul_q);
          state <= S_EFF;
        end
        S_EFF: begin
          eff_q[wheel] <= eff_clamp;
          if (wheel) begin
            state <= S_OUT;
          end else begin
            wheel <= 1'b1;
            state <= S_MSPD;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {err_q[1], err_q[0], spd_q[1], spd_q[0], eff_q[1], eff_q[0]};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tuser[0] == dwpi_pkg::OP_START) |=> (integ[0] == '0 && integ[1] == '0))
    else $error("start transfer did not clear the integrators");

  a_tick_begins: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && s_tuser[0] == dwpi_pkg::OP_TICK) |=> (state == S_MSPD && !wheel))
    else $error("tick transfer did not start the left wheel");

  a_out_waits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_tvalid && !m_tready) |=> (state == S_OUT))
    else $error("result left the sequencer while the output was still pending");

  a_effort_left_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !m_tvalid) |=>
      (signed'(m_tdata[FW-1:0]) <= signed'({1'b0, limit}) &&
       signed'(m_tdata[FW-1:0]) >= -signed'({1'b0, limit})))
    else $error("left effort outside the limit");

  a_wheel_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_EFF && !wheel) |=> (state == S_MSPD && wheel))
    else $error("right wheel did not follow the left wheel");

endmodule

[dv/tb_dual_wheel_pi_speed_control.sv]
// Self-checking testbench for the dual-wheel PI speed controller.
// Predicts every tick result and checks the stream output field by field.
// Depends on dwpi_pkg and on the dual_wheel_pi_speed_control design.
module tb_dual_wheel_pi_speed_control;
  import dwpi_pkg::*;

  typedef struct packed {
    logic signed [ERR_W-1:0]    speed_err_right;
    logic signed [ERR_W-1:0]    speed_err_left;
    logic signed [SPEED_W-1:0]  speed_right;
    logic signed [SPEED_W-1:0]  speed_left;
    logic signed [EFFORT_W-1:0] effort_right;
    logic signed [EFFORT_W-1:0] effort_left;
  } drive_result_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // Fields from bit 0: enc_left[15:0], enc_right[31:16].
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // Fields from bit 0: op[0].
  logic [0:0]            s_tuser = OP_TICK;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  // Fields from bit 0: effort_left, effort_right, speed_left, speed_right,
  // speed_err_left, speed_err_right.
  logic [OUT_DATA_W-1:0] m_tdata;

  dual_wheel_pi_speed_control dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Controller state as predicted by the testbench.
  logic signed [TGT_W-1:0] target_m [2];
  logic [GAIN_W-1:0]       scale_m, kp_m, ki_m;
  logic [LIM_W-1:0]        limit_m;
  logic [ENC_W-1:0]        last_count_m [2];
  longint                  integral_m [2];

  drive_result_t pending_results [$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_ticks = 0, n_starts = 0, n_writes = 0, n_settings = 0;
  int n_checked = 0, n_mismatch = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  function automatic longint clip_signed(longint v, int bits);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic void wheel_speed_loop(input int w, input logic [ENC_W-1:0] enc,
                                           output logic signed [EFFORT_W-1:0] eff,
                                           output logic signed [SPEED_W-1:0] spd,
                                           output logic signed [ERR_W-1:0] err);
    logic signed [ENC_W-1:0] delta;
    longint sp, e, acc, lim;
    delta = enc - last_count_m[w];
    last_count_m[w] = enc;
    sp = clip_signed((longint'(delta) * longint'(scale_m) + ROUND_HALF) >>> FRAC_BITS,
                     SPEED_W);
    e = longint'(target_m[w]) - sp;
    integral_m[w] = clip_signed(integral_m[w] + e, INTEGRAL_BITS_DEF);
    acc = longint'(kp_m) * e + longint'(ki_m) * integral_m[w];
    acc = (acc + ROUND_HALF) >>> FRAC_BITS;
    lim = longint'(limit_m);
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    eff = EFFORT_W'(acc);
    spd = SPEED_W'(sp);
    err = ERR_W'(e);
  endfunction

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("Mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    drive_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_results.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("Unexpected result transfer: %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        compare_field("effort_left", longint'(want.effort_left),
                      longint'(got.effort_left));
        compare_field("effort_right", longint'(want.effort_right),
                      longint'(got.effort_right));
        compare_field("speed_left", longint'(want.speed_left),
                      longint'(got.speed_left));
        compare_field("speed_right", longint'(want.speed_right),
                      longint'(got.speed_right));
        compare_field("speed_err_left", longint'(want.speed_err_left),
                      longint'(got.speed_err_left));
        compare_field("speed_err_right", longint'(want.speed_err_right),
                      longint'(got.speed_err_right));
      end
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SENDER:   begin send_idle_pct = 61; recv_stall_pct = 0;  end
      IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      IDLE_BOTH:     begin send_idle_pct = 17; recv_stall_pct = 17; end
      default:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endtask

  task automatic send_item(input logic op, input logic [ENC_W-1:0] enc_l,
                           input logic [ENC_W-1:0] enc_r);
    drive_result_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {enc_r, enc_l};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_START) begin
      integral_m[0] = '0;
      integral_m[1] = '0;
      n_starts++;
    end else begin
      wheel_speed_loop(0, enc_l, want.effort_left, want.speed_left, want.speed_err_left);
      wheel_speed_loop(1, enc_r, want.effort_right, want.speed_right, want.speed_err_right);
      pending_results.push_back(want);
      n_ticks++;
    end
  endtask

  // Holds the sender off until every result is in, then lets a start finish too.
  task automatic wait_idle;
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_TARGET_LEFT:  target_m[0] = val;
      REG_TARGET_RIGHT: target_m[1] = val;
      REG_SPEED_SCALE:  scale_m = val;
      REG_PROP_GAIN:    kp_m = val;
      REG_INTEG_GAIN:   ki_m = val;
      REG_EFFORT_LIMIT: limit_m = val[LIM_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic configure(input logic [15:0] tl, input logic [15:0] tr, input logic [15:0] sc,
                           input logic [15:0] kp, input logic [15:0] ki, input logic [15:0] lim);
    wait_idle();
    write_reg(REG_TARGET_LEFT, tl);
    write_reg(REG_TARGET_RIGHT, tr);
    write_reg(REG_SPEED_SCALE, sc);
    write_reg(REG_PROP_GAIN, kp);
    write_reg(REG_INTEG_GAIN, ki);
    write_reg(REG_EFFORT_LIMIT, lim);
    n_settings++;
  endtask

  task automatic test_reset_defaults;
    set_idling(IDLE_NONE);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h7FFF, 16'h8000);
    send_item(OP_TICK, 16'h8000, 16'h7FFF);
    send_item(OP_TICK, 16'h5555, 16'hAAAA);
    send_item(OP_TICK, 16'hAAAA, 16'h5555);
    send_item(OP_START, 16'hFFFF, 16'hFFFF);
    send_item(OP_TICK, 16'hFFFF, 16'h0000);
  endtask

  task automatic test_register_extremes;
    configure(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1023);
    send_item(OP_TICK, 16'h7FFF, 16'h8000);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    send_item(OP_TICK, 16'h8001, 16'h7FFF);
    // Writes to unused indexes must be ignored; high bits of the limit are dropped,
    // which here leaves a zero limit.
    wait_idle();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'h1234);
    write_reg(REG_EFFORT_LIMIT, 16'hFC00);
    send_item(OP_TICK, 16'h0100, 16'hFF00);
    send_item(OP_TICK, 16'h0000, 16'h0000);
    configure(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd1023);
    send_item(OP_TICK, 16'h1234, 16'hEDCB);
    configure(16'hFFFF, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'd1);
    send_item(OP_TICK, 16'h1235, 16'hEDCA);
    send_item(OP_TICK, 16'h12B5, 16'hED4A);
  endtask

  task automatic test_start_clears;
    configure(16'd500, -16'sd500, 16'd256, 16'd64, 16'd32, 16'd1023);
    send_item(OP_TICK, 16'd10, 16'd10);
    send_item(OP_TICK, 16'd20, 16'd20);
    send_item(OP_TICK, 16'd30, 16'd30);
    send_item(OP_START, 16'h1357, 16'h2468);
    send_item(OP_TICK, 16'd40, 16'd40);
    send_item(OP_START, 16'h0000, 16'h0000);
    send_item(OP_START, 16'hFFFF, 16'hFFFF);
    send_item(OP_TICK, 16'd45, 16'd35);
  endtask

  task automatic test_random_phases;
    logic [15:0] tl, tr, sc, kp, ki, lim;
    int span, r;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(7))
        0: tl = 16'h8000;
        1: tl = 16'h7FFF;
        default: tl = 16'($urandom_range(4000) - 2000);
      endcase
      case ($urandom_range(7))
        0: tr = 16'h8000;
        1: tr = 16'h7FFF;
        default: tr = 16'($urandom_range(4000) - 2000);
      endcase
      case ($urandom_range(7))
        0: sc = 16'h0000;
        1: sc = 16'hFFFF;
        default: sc = 16'($urandom_range(1024));
      endcase
      case ($urandom_range(7))
        0: kp = 16'h0000;
        1: kp = 16'hFFFF;
        default: kp = 16'($urandom_range(1024));
      endcase
      case ($urandom_range(7))
        0: ki = 16'h0000;
        1: ki = 16'hFFFF;
        default: ki = 16'($urandom_range(128));
      endcase
      case ($urandom_range(7))
        0: lim = 16'd0;
        1: lim = 16'd1023;
        default: lim = 16'($urandom_range(1023));
      endcase
      configure(tl, tr, sc, kp, ki, lim);
      set_idling(idle_mode_t'(ph % 4));
      for (int i = 0; i < 100; i++) begin
        r = $urandom_range(99);
        span = $urandom_range(1) ? 64 : 1024;
        if (r < 6)
          send_item(OP_START, 16'($urandom), 16'($urandom));
        else if (r < 14)
          send_item(OP_TICK, 16'($urandom), 16'($urandom));
        else
          send_item(OP_TICK,
                    ENC_W'(last_count_m[0] + $urandom_range(2 * span) - span),
                    ENC_W'(last_count_m[1] + $urandom_range(2 * span) - span));
      end
    end
    set_idling(IDLE_NONE);
  endtask

  initial begin
    target_m[0] = TARGET_RESET;
    target_m[1] = TARGET_RESET;
    scale_m = SCALE_RESET;
    kp_m = KP_RESET;
    ki_m = KI_RESET;
    limit_m = LIMIT_RESET;
    last_count_m[0] = '0;
    last_count_m[1] = '0;
    integral_m[0] = '0;
    integral_m[1] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_register_extremes();
    test_start_clears();
    test_random_phases();
    wait_idle();
    $display("Run covered %0d ticks, %0d starts, %0d register writes over %0d settings.",
             n_ticks, n_starts, n_writes, n_settings);
    $display("Results checked: %0d, mismatches: %0d.", n_checked, n_mismatch);
    if (n_mismatch == 0 && pending_results.size() == 0)
      $display("tb_dual_wheel_pi_speed_control: PASS");
    else
      $display("tb_dual_wheel_pi_speed_control: FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d results outstanding.", pending_results.size());
    $display("tb_dual_wheel_pi_speed_control: FAIL");
    $finish;
  end

endmodule

[sim.f]
design/dwpi_pkg.sv
design/dual_wheel_pi_speed_control.sv
dv/tb_dual_wheel_pi_speed_control.sv
